/* hdl/psrt_pkg.sv */
package psrt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TRIG_BITS = 16;
  localparam int ROM_W = 17;
  localparam int TRIG_W = 18;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  localparam logic signed [31:0] SCALE_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_POS_X,
    REG_POS_Y,
    REG_POS_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_ANGLES
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cz;
    logic signed [TRIG_W-1:0] sz;
  } trig_t;

  // {clamped, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > S32_MAX) begin
      r = {1'b1, S32_MAX[31:0]};
    end else if (v < S32_MIN) begin
      r = {1'b1, S32_MIN[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

/* hdl/point_scale_rotate_translate_core.sv */
// Scales a signed Q16.16 point per axis, optionally rotates it about X, Y
// then Z, and translates it, saturating every sum and flagging any clamp in
// m_tuser. One point per clock unless the output stalls or the trig lookup
// is busy, through scale multiply and clamp, three rotation stages of
// multiply then sum, and output add. Sine and cosine come from a ROM of
// SINE_TABLE_ENTRIES + 1 entries with one read port, looked up into
// registers six reads in a row; after reset and every euler_angles write,
// s_tready stays low while it runs. The configuration port is always ready.
module point_scale_rotate_translate_core
  import psrt_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // local_x, local_y, local_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,  // world_x, world_y, world_z
  output logic [0:0]  m_tuser,  // saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  logic               mode_full_trs;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] position_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;
  logic [47:0]        euler_angles;

  logic        restart;
  logic        trig_busy;
  trig_t       trig;
  logic        en;
  logic        in_vld;
  logic        sc_vld;
  pt_t         sc_pt;
  logic        r1_vld;
  pt_t         r1_pt;
  logic        r2_vld;
  pt_t         r2_pt;
  logic        r3_vld;
  pt_t         r3_pt;
  logic [32:0] wx;
  logic [32:0] wy;
  logic [32:0] wz;

  assign cfg_ready = 1'b1;
  assign restart = cfg_valid && cfg_ready && (cfg_index == REG_ANGLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_full_trs <= 1'b0;
      position_x <= '0;
      position_y <= '0;
      position_z <= '0;
      scale_x <= SCALE_ONE;
      scale_y <= SCALE_ONE;
      scale_z <= SCALE_ONE;
      euler_angles <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:    mode_full_trs <= cfg_data[0];
        REG_POS_X:   position_x <= cfg_data[31:0];
        REG_POS_Y:   position_y <= cfg_data[31:0];
        REG_POS_Z:   position_z <= cfg_data[31:0];
        REG_SCALE_X: scale_x <= cfg_data[31:0];
        REG_SCALE_Y: scale_y <= cfg_data[31:0];
        REG_SCALE_Z: scale_z <= cfg_data[31:0];
        REG_ANGLES:  euler_angles <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en && !trig_busy;
  assign in_vld = s_tvalid && s_tready;

  psrt_trig #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_trig (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .angles  (euler_angles),
    .busy    (trig_busy),
    .trig    (trig)
  );

  psrt_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (in_vld),
    .x       (s_tdata[31:0]),
    .y       (s_tdata[63:32]),
    .z       (s_tdata[95:64]),
    .scale_x (scale_x),
    .scale_y (scale_y),
    .scale_z (scale_z),
    .out_vld (sc_vld),
    .out_pt  (sc_pt)
  );

  psrt_rot u_rot_x (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .axis          (AXIS_X),
    .mode_full_trs (mode_full_trs),
    .c             (trig.cx),
    .s             (trig.sx),
    .in_vld        (sc_vld),
    .in_pt         (sc_pt),
    .out_vld       (r1_vld),
    .out_pt        (r1_pt)
  );

  psrt_rot u_rot_y (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .axis          (AXIS_Y),
    .mode_full_trs (mode_full_trs),
    .c             (trig.cy),
    .s             (trig.sy),
    .in_vld        (r1_vld),
    .in_pt         (r1_pt),
    .out_vld       (r2_vld),
    .out_pt        (r2_pt)
  );

  psrt_rot u_rot_z (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .axis          (AXIS_Z),
    .mode_full_trs (mode_full_trs),
    .c             (trig.cz),
    .s             (trig.sz),
    .in_vld        (r2_vld),
    .in_pt         (r2_pt),
    .out_vld       (r3_vld),
    .out_pt        (r3_pt)
  );

  assign wx = sat32(64'(r3_pt.x) + 64'(position_x));
  assign wy = sat32(64'(r3_pt.y) + 64'(position_y));
  assign wz = sat32(64'(r3_pt.z) + 64'(position_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {wz[31:0], wy[31:0], wx[31:0]};
      m_tuser[0] <= r3_pt.flag | wx[32] | wy[32] | wz[32];
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  a_angle_write_lookup: assert property (@(posedge clk) disable iff (rst)
    restart |=> trig_busy)
    else $error("angle write did not start trig lookup");

  a_reset_lookup: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> trig_busy)
    else $error("trig lookup not running after reset");

endmodule

/* hdl/psrt_trig.sv */
module psrt_trig
  import psrt_pkg::*;
#(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic [47:0] angles,
  output logic        busy,
  output trig_t       trig
);

  localparam int N = SINE_TABLE_ENTRIES;
  localparam int IW = $clog2(N + 1);
  localparam int PW = 14 + IW;
  localparam logic [2:0] SEQ_COUNT = 3'd6;

  typedef enum logic [2:0] {
    SEL_CX,
    SEL_SX,
    SEL_CY,
    SEL_SY,
    SEL_CZ,
    SEL_SZ
  } sel_t;

  function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x = (k * HALF_PI_Q30) / 64'(N);
    x2 = (x * x) >> 30;
    t = x;
    s = x;
    t = ((t * x2) >> 30) / 64'd6;   s = s - t;
    t = ((t * x2) >> 30) / 64'd20;  s = s + t;
    t = ((t * x2) >> 30) / 64'd42;  s = s - t;
    t = ((t * x2) >> 30) / 64'd72;  s = s + t;
    t = ((t * x2) >> 30) / 64'd110; s = s - t;
    t = ((t * x2) >> 30) / 64'd156; s = s + t;
    t = ((t * x2) >> 30) / 64'd210; s = s - t;
    t = ((t * x2) >> 30) / 64'd272; s = s + t;
    v = (s + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return v[ROM_W-1:0];
  endfunction

  logic [ROM_W-1:0] rom [N+1];

  for (genvar k = 0; k <= N; k++) begin : g_rom
    assign rom[k] = sine_entry(64'(k));
  end

  logic [2:0]       cnt;
  logic             issue;
  logic [15:0]      ang_raw;
  logic [15:0]      ang;
  logic [PW-1:0]    idx_prod;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    addr;
  logic [ROM_W-1:0] rom_q;
  logic             rd_vld;
  logic             rd_neg;
  sel_t             rd_sel;
  logic signed [TRIG_W-1:0] mag;
  logic signed [TRIG_W-1:0] tval;

  assign issue = busy && (cnt != SEQ_COUNT);

  always_comb begin
    case (cnt[2:1])
      2'd0:    ang_raw = angles[15:0];
      2'd1:    ang_raw = angles[31:16];
      default: ang_raw = angles[47:32];
    endcase
  end

  // even steps are cosines: sin(a + quarter turn)
  assign ang = cnt[0] ? ang_raw : ang_raw + QUARTER_TURN;
  assign idx_prod = PW'(ang[13:0]) * PW'(N);
  assign idx = idx_prod[PW-1:14];
  assign addr = ang[14] ? IW'(N) - idx : idx;

  assign mag = signed'({1'b0, rom_q});
  assign tval = rd_neg ? -mag : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt <= '0;
      rd_vld <= 1'b0;
    end else if (restart) begin
      busy <= 1'b1;
      cnt <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        cnt <= cnt + 3'd1;
      end
      if (rd_vld && rd_sel == SEL_SZ) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= rom[addr];
    rd_neg <= ang[15];
    rd_sel <= sel_t'(cnt);
    if (rd_vld) begin
      case (rd_sel)
        SEL_CX:  trig.cx <= tval;
        SEL_SX:  trig.sx <= tval;
        SEL_CY:  trig.cy <= tval;
        SEL_SY:  trig.sy <= tval;
        SEL_CZ:  trig.cz <= tval;
        SEL_SZ:  trig.sz <= tval;
        default: ;
      endcase
    end
  end

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !rd_vld)
    else $error("table read issued while lookup idle");

  a_read_in_busy: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> busy)
    else $error("table data returned outside lookup");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rd_vld && rd_sel == SEL_SZ && !restart) |=> !busy)
    else $error("lookup did not finish after last entry");

endmodule

/* hdl/psrt_scale.sv */
module psrt_scale
  import psrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  output logic               out_vld,
  output pt_t                out_pt
);

  logic               vld_a;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [63:0] pz;
  logic [32:0]        sx;
  logic [32:0]        sy;
  logic [32:0]        sz;

  assign sx = sat32(px >>> FRAC_BITS);
  assign sy = sat32(py >>> FRAC_BITS);
  assign sz = sat32(pz >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
      out_vld <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px <= 64'(x) * 64'(scale_x);
      py <= 64'(y) * 64'(scale_y);
      pz <= 64'(z) * 64'(scale_z);
      out_pt.x <= sx[31:0];
      out_pt.y <= sy[31:0];
      out_pt.z <= sz[31:0];
      out_pt.flag <= sx[32] | sy[32] | sz[32];
    end
  end

endmodule

/* hdl/psrt_rot.sv */
module psrt_rot
  import psrt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  axis_t                    axis,
  input  logic                     mode_full_trs,
  input  logic signed [TRIG_W-1:0] c,
  input  logic signed [TRIG_W-1:0] s,
  input  logic                     in_vld,
  input  pt_t                      in_pt,
  output logic                     out_vld,
  output pt_t                      out_pt
);

  localparam int PRW = 32 + TRIG_W;

  logic signed [31:0]       u;
  logic signed [31:0]       v;
  logic signed [TRIG_W-1:0] s2;
  logic                     vld_a;
  pt_t                      pt_a;
  logic signed [PRW-1:0]    p0;
  logic signed [PRW-1:0]    p1;
  logic signed [PRW-1:0]    p2;
  logic signed [PRW-1:0]    p3;
  logic signed [63:0]       q0;
  logic signed [63:0]       q1;
  logic signed [63:0]       q2;
  logic signed [63:0]       q3;
  logic [32:0]              o1;
  logic [32:0]              o2;
  pt_t                      res;

  always_comb begin
    case (axis)
      AXIS_X: begin
        u = in_pt.y;
        v = in_pt.z;
        s2 = s;
      end
      AXIS_Y: begin
        u = in_pt.x;
        v = in_pt.z;
        s2 = -s;
      end
      default: begin
        u = in_pt.x;
        v = in_pt.y;
        s2 = s;
      end
    endcase
  end

  assign q0 = 64'(p0 >>> TRIG_BITS);
  assign q1 = 64'(p1 >>> TRIG_BITS);
  assign q2 = 64'(p2 >>> TRIG_BITS);
  assign q3 = 64'(p3 >>> TRIG_BITS);
  assign o1 = sat32((axis == AXIS_Y) ? q0 + q1 : q0 - q1);
  assign o2 = sat32(q2 + q3);

  always_comb begin
    res = pt_a;
    if (mode_full_trs) begin
      res.flag = pt_a.flag | o1[32] | o2[32];
      case (axis)
        AXIS_X: begin
          res.y = o1[31:0];
          res.z = o2[31:0];
        end
        AXIS_Y: begin
          res.x = o1[31:0];
          res.z = o2[31:0];
        end
        default: begin
          res.x = o1[31:0];
          res.y = o2[31:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_a <= in_vld;
      out_vld <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= PRW'(u) * PRW'(c);
      p1 <= PRW'(v) * PRW'(s);
      p2 <= PRW'(u) * PRW'(s2);
      p3 <= PRW'(v) * PRW'(c);
      pt_a <= in_pt;
      out_pt <= res;
    end
  end

endmodule
